// ----- rtl/b64se_pkg.sv -----
// shared types, constants and alphabet lookup for the base64 stream encoder
package b64se_pkg;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int CODE_W    = 7;
   localparam int SEXTET_W  = 6;
   localparam int MAX_SYMS  = 4;
   localparam int SYM_IDX_W = $clog2(MAX_SYMS);

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // ascii codes
   localparam logic [CODE_W-1:0] PAD_CODE   = 7'd61;  // '='
   localparam logic [CODE_W-1:0] PLUS_CODE  = 7'd43;  // '+'
   localparam logic [CODE_W-1:0] MINUS_CODE = 7'd45;  // '-'
   localparam logic [CODE_W-1:0] UPPER_A    = 7'd65;
   localparam logic [CODE_W-1:0] LOWER_A    = 7'd97;
   localparam logic [CODE_W-1:0] DIGIT_0    = 7'd48;

   // leftover count codes (pairs of held bits)
   localparam logic [1:0] LC_NONE = 2'd0;
   localparam logic [1:0] LC_TWO  = 2'd1;
   localparam logic [1:0] LC_FOUR = 2'd2;

   // one classified byte: up to four symbols to emit
   typedef struct packed {
      logic [MAX_SYMS-1:0][CODE_W-1:0] codes;
      logic [SYM_IDX_W-1:0]            last_idx;
      logic                            end_msg;
   } job_type;

   // queue status seen by front, back and top
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // sextet to ascii symbol
   function automatic logic [CODE_W-1:0] enc_sym(input logic [SEXTET_W-1:0] idx);
      logic [CODE_W-1:0] wide;
      wide = {1'b0, idx};
      case (idx) inside
         [6'd0:6'd25]:  enc_sym = UPPER_A + wide;
         [6'd26:6'd51]: enc_sym = LOWER_A + wide - 7'd26;
         [6'd52:6'd61]: enc_sym = DIGIT_0 + wide - 7'd52;
         6'd62:         enc_sym = PLUS_CODE;
         default:       enc_sym = MINUS_CODE;
      endcase
   endfunction

endpackage

// ----- rtl/b64se_front.sv -----
// front end: joins each byte with leftover bits and builds a symbol job
module b64se_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [b64se_pkg::BYTE_W-1:0] data_byte,
   input  logic                        end_of_message,
   input  b64se_pkg::queue_stat_type   q_stat,
   output logic                        job_push,
   output b64se_pkg::job_type          job
);
   import b64se_pkg::*;

   logic [3:0] leftover_bits_ff, leftover_bits_in;
   logic [1:0] leftover_count_ff, leftover_count_in;

   logic [SEXTET_W-1:0]  sym0, sym1;
   logic [3:0]           rem_bits;
   logic [1:0]           rem_cnt;
   logic [SYM_IDX_W-1:0] regular_last;

   assign job_push = push && !q_stat.full;

   // split the joined bits into full sextets and a remainder
   always_comb begin
      sym1         = '0;
      regular_last = '0;
      case (leftover_count_ff)
         LC_TWO: begin
            sym0     = {leftover_bits_ff[1:0], data_byte[7:4]};
            rem_bits = data_byte[3:0];
            rem_cnt  = LC_FOUR;
         end
         LC_FOUR: begin
            sym0         = {leftover_bits_ff[3:0], data_byte[7:6]};
            sym1         = data_byte[5:0];
            rem_bits     = '0;
            rem_cnt      = LC_NONE;
            regular_last = SYM_IDX_W'(1);
         end
         default: begin
            sym0     = data_byte[7:2];
            rem_bits = {2'b00, data_byte[1:0]};
            rem_cnt  = LC_TWO;
         end
      endcase
   end

   // build the job, with flush symbol and padding at end of message
   always_comb begin
      job.codes    = {MAX_SYMS{PAD_CODE}};
      job.codes[0] = enc_sym(sym0);
      job.codes[1] = enc_sym(sym1);
      job.last_idx = regular_last;
      job.end_msg  = end_of_message;
      if (end_of_message) begin
         case (rem_cnt)
            LC_TWO: begin
               job.codes[1] = enc_sym({rem_bits[1:0], 4'b0000});
               job.last_idx = SYM_IDX_W'(3);
            end
            LC_FOUR: begin
               job.codes[1] = enc_sym({rem_bits[3:0], 2'b00});
               job.last_idx = SYM_IDX_W'(2);
            end
            default: begin
               job.last_idx = regular_last;
            end
         endcase
      end
   end

   // leftover state update
   always_comb begin
      leftover_bits_in  = leftover_bits_ff;
      leftover_count_in = leftover_count_ff;
      if (job_push) begin
         if (end_of_message) begin
            leftover_bits_in  = '0;
            leftover_count_in = LC_NONE;
         end else begin
            leftover_bits_in  = rem_bits;
            leftover_count_in = rem_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_bits_ff  <= '0;
         leftover_count_ff <= LC_NONE;
      end else begin
         leftover_bits_ff  <= leftover_bits_in;
         leftover_count_ff <= leftover_count_in;
      end
   end

endmodule

// ----- rtl/b64se_queue.sv -----
// short job queue between front and back
module b64se_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  b64se_pkg::job_type        wr_job,
   input  logic                      rd_en,
   output b64se_pkg::job_type        rd_job,
   output b64se_pkg::queue_stat_type stat
);
   import b64se_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr, do_rd;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_wr      = wr_en && !stat.full;
   assign do_rd      = rd_en && !stat.empty;
   assign rd_job     = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

// ----- rtl/b64se_back.sv -----
// back end: steps through a job into the output register, one symbol per cycle while it is free or popped
module b64se_back (
   input  logic                        clock,
   input  logic                        reset,
   input  b64se_pkg::job_type          job,
   input  b64se_pkg::queue_stat_type   q_stat,
   output logic                        job_pop,
   input  logic                        pop,
   output logic                        empty,
   output logic [b64se_pkg::CODE_W-1:0] symbol_code,
   output logic                        last_symbol
);
   import b64se_pkg::*;

   logic                 out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic                 last_ff, last_in;
   logic [SYM_IDX_W-1:0] sym_idx_ff, sym_idx_in;
   logic                 load, at_last;

   assign empty       = !out_valid_ff;
   assign symbol_code = code_ff;
   assign last_symbol = last_ff;

   // load a new symbol when the output register is free or being taken
   assign load    = !q_stat.empty && (!out_valid_ff || pop);
   assign at_last = (sym_idx_ff == job.last_idx);
   assign job_pop = load && at_last;

   always_comb begin
      out_valid_in = out_valid_ff;
      sym_idx_in   = sym_idx_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         code_in      = job.codes[sym_idx_ff];
         last_in      = job.end_msg && at_last;
         sym_idx_in   = at_last ? '0 : sym_idx_ff + 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sym_idx_ff   <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         sym_idx_ff   <= sym_idx_in;
      end
      code_ff <= code_in;
      last_ff <= last_in;
   end

endmodule

// ----- rtl/base64_stream_encoder.sv -----
// top level of the base64 stream encoder: front, job queue and back
// with the back idle, a byte's job is registered in the queue, then its first symbol in the output register
// the back gives one symbol per cycle unless the output is held unpopped; a byte yields one to four symbols
// a two-entry job queue lets the front take bytes while the back drains earlier ones
// reset: synchronous, active high; clears leftover bits, queue and output register
module base64_stream_encoder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [b64se_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                         req_end_of_message,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [b64se_pkg::CODE_W-1:0] rsp_symbol_code,
   output logic                         rsp_last_symbol
);
   import b64se_pkg::*;

   job_type        front_job, head_job;
   logic           job_push, job_pop;
   queue_stat_type q_stat;

   assign req_full = q_stat.full;

   // classify bytes into symbol jobs
   b64se_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .data_byte      (req_data_byte),
      .end_of_message (req_end_of_message),
      .q_stat         (q_stat),
      .job_push       (job_push),
      .job            (front_job)
   );

   // decoupling queue
   b64se_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (job_push),
      .wr_job (front_job),
      .rd_en  (job_pop),
      .rd_job (head_job),
      .stat   (q_stat)
   );

   // emit symbols
   b64se_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job         (head_job),
      .q_stat      (q_stat),
      .job_pop     (job_pop),
      .pop         (rsp_pop),
      .empty       (rsp_empty),
      .symbol_code (rsp_symbol_code),
      .last_symbol (rsp_last_symbol)
   );

   // queue cannot be full and empty together
   assert property (@(posedge clock) disable iff (reset) !(q_stat.full && q_stat.empty))
      else $error("job queue full and empty at once");

   // output register starts empty after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present right after reset");

   // taking the last result with no job pending leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && q_stat.empty) |=> rsp_empty)
      else $error("result appeared with no job queued");

   // an accepted byte always leaves a job in the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && q_stat.empty) |=> !q_stat.empty)
      else $error("accepted byte lost before the queue");

endmodule
